/* hw/rtl/cau_pkg.sv */
package cau_pkg;

	typedef enum logic [3:0] {
		ACT_ADD   = 4'd0,
		ACT_SUB   = 4'd1,
		ACT_MUL   = 4'd2,
		ACT_DIV   = 4'd3,
		ACT_CONJ  = 4'd4,
		ACT_SCALE = 4'd5,
		ACT_MAG   = 4'd6,
		ACT_SQMAG = 4'd7,
		ACT_RECIP = 4'd8,
		ACT_ZERO  = 4'd9
	} act_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic vld;
		act_t act;
		logic zero;
		logic denz;
		logic neg_re;
		logic neg_im;
	} ctl_t;

endpackage

/* hw/rtl/cau_front.sv */
module cau_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [3:0]          action,
	input  logic signed [W-1:0] a_re,
	input  logic signed [W-1:0] a_im,
	input  logic signed [W-1:0] b_re,
	input  logic signed [W-1:0] b_im,
	output cau_pkg::ctl_t       ctl,
	output logic [2*W-1:0]      mag_re,
	output logic [2*W-1:0]      mag_im,
	output logic [2*W-1:0]      den,
	output logic signed [W:0]   qre,
	output logic signed [W:0]   qim
);
	import cau_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	act_t act_s1, act_s2, act_s3, act_s4;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1, ar_s2, ai_s2;
	logic signed [W-1:0] x_c, y_c;
	logic signed [2*W-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [W:0] qre_c, qim_c, qre_s2, qim_s2, qre_s3, qim_s3, qre_s4, qim_s4;
	logic zero_c, zero_s2, zero_s3, zero_s4;
	logic signed [2*W:0] arx, aix, sre_c, sim_c, sre_s3, sim_s3;
	logic [2*W-1:0] den_c, den_s3, den_s4, mag_re_s4, mag_im_s4;
	logic neg_re_s4, neg_im_s4, denz_s4;

	always_comb begin
		x_c = (act_s1 == ACT_DIV) ? br_s1 : ar_s1;
		y_c = (act_s1 == ACT_DIV) ? bi_s1 : ai_s1;
		qre_c = '0;
		qim_c = '0;
		case (act_s1)
			ACT_ADD: begin
				qre_c = (W+1)'(ar_s1) + (W+1)'(br_s1);
				qim_c = (W+1)'(ai_s1) + (W+1)'(bi_s1);
			end
			ACT_SUB: begin
				qre_c = (W+1)'(ar_s1) - (W+1)'(br_s1);
				qim_c = (W+1)'(ai_s1) - (W+1)'(bi_s1);
			end
			ACT_CONJ: begin
				qre_c = (W+1)'(ar_s1);
				qim_c = -((W+1)'(ai_s1));
			end
			default: ;
		endcase
		zero_c = (act_s1 == ACT_ZERO) && (ar_s1 == '0) && (ai_s1 == '0);
	end

	always_comb begin
		arx = (2*W+1)'(ar_s2) <<< F;
		aix = (2*W+1)'(ai_s2) <<< F;
		sre_c = '0;
		sim_c = '0;
		case (act_s2)
			ACT_MUL: begin
				sre_c = (2*W+1)'(p1_s2) - (2*W+1)'(p2_s2);
				sim_c = (2*W+1)'(p3_s2) + (2*W+1)'(p4_s2);
			end
			ACT_DIV: begin
				sre_c = (2*W+1)'(p1_s2) + (2*W+1)'(p2_s2);
				sim_c = (2*W+1)'(p4_s2) - (2*W+1)'(p3_s2);
			end
			ACT_SCALE: begin
				sre_c = (2*W+1)'(p1_s2);
				sim_c = (2*W+1)'(p4_s2);
			end
			ACT_RECIP: begin
				sre_c = arx;
				sim_c = -aix;
			end
			default: ;
		endcase
		den_c = $unsigned(p5_s2) + $unsigned(p6_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= act_t'(action);
			ar_s1  <= a_re;
			ai_s1  <= a_im;
			br_s1  <= b_re;
			bi_s1  <= b_im;

			act_s2  <= act_s1;
			ar_s2   <= ar_s1;
			ai_s2   <= ai_s1;
			p1_s2   <= ar_s1 * br_s1;
			p2_s2   <= ai_s1 * bi_s1;
			p3_s2   <= ar_s1 * bi_s1;
			p4_s2   <= ai_s1 * br_s1;
			p5_s2   <= x_c * x_c;
			p6_s2   <= y_c * y_c;
			qre_s2  <= qre_c;
			qim_s2  <= qim_c;
			zero_s2 <= zero_c;

			act_s3  <= act_s2;
			sre_s3  <= sre_c;
			sim_s3  <= sim_c;
			den_s3  <= den_c;
			qre_s3  <= qre_s2;
			qim_s3  <= qim_s2;
			zero_s3 <= zero_s2;

			act_s4    <= act_s3;
			neg_re_s4 <= sre_s3[2*W];
			neg_im_s4 <= sim_s3[2*W];
			mag_re_s4 <= sre_s3[2*W] ? (2*W)'(-sre_s3) : (2*W)'(sre_s3);
			mag_im_s4 <= sim_s3[2*W] ? (2*W)'(-sim_s3) : (2*W)'(sim_s3);
			den_s4    <= den_s3;
			denz_s4   <= (den_s3 == '0);
			qre_s4    <= qre_s3;
			qim_s4    <= qim_s3;
			zero_s4   <= zero_s3;
		end
	end

	assign ctl = '{vld: vld_s4, act: act_s4, zero: zero_s4, denz: denz_s4,
		neg_re: neg_re_s4, neg_im: neg_im_s4};
	assign mag_re = mag_re_s4;
	assign mag_im = mag_im_s4;
	assign den    = den_s4;
	assign qre    = qre_s4;
	assign qim    = qim_s4;

endmodule

/* hw/rtl/cau_div.sv */
module cau_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] mag,
	input  logic [2*W-1:0] den,
	output logic [W+1:0]   quo,
	output logic           ovf
);
	localparam int NS = W + 2;
	localparam int RW = 2*W + 1;
	localparam int SH = W + 1 - F;

	logic [RW-1:0]  rem_in;
	logic [W+1:0]   lo_in;
	logic           ovf_in;
	logic [RW-1:0]  rem_s [NS];
	logic [W+1:0]   lo_s  [NS];
	logic [W+1:0]   q_s   [NS];
	logic [2*W-1:0] den_s [NS];
	logic           ovf_s [NS];

	// quotient of (mag << F+1) / den, one bit per stage, msb first
	assign rem_in = RW'(mag >> SH);
	assign lo_in  = {mag[W-F:0], {(F+1){1'b0}}};
	assign ovf_in = rem_in >= {1'b0, den};

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [RW-1:0]  r_in, t, d_ext;
		logic [W+1:0]   l_in, q_in;
		logic [2*W-1:0] d_in;
		logic           o_in, ge;

		if (k == 0) begin : g_head
			assign r_in = rem_in;
			assign l_in = lo_in;
			assign q_in = '0;
			assign d_in = den;
			assign o_in = ovf_in;
		end else begin : g_tail
			assign r_in = rem_s[k-1];
			assign l_in = lo_s[k-1];
			assign q_in = q_s[k-1];
			assign d_in = den_s[k-1];
			assign o_in = ovf_s[k-1];
		end

		assign t     = {r_in[RW-2:0], l_in[W+1]};
		assign d_ext = {1'b0, d_in};
		assign ge    = t >= d_ext;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? t - d_ext : t;
				lo_s[k]  <= {l_in[W:0], 1'b0};
				q_s[k]   <= {q_in[W:0], ge};
				den_s[k] <= d_in;
				ovf_s[k] <= o_in;
			end
		end
	end

	assign quo = q_s[NS-1];
	assign ovf = ovf_s[NS-1];

endmodule

/* hw/rtl/cau_sqrt.sv */
module cau_sqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] s,
	output logic [W+1:0]   root,
	output logic [W+3:0]   rem
);
	localparam int NS = W + 2;
	localparam int SW = 2*W + 4;
	localparam int RW = W + 4;

	logic [RW-1:0] rem_s  [NS];
	logic [W+1:0]  root_s [NS];
	logic [SW-1:0] lo_s   [NS];

	// digit-by-digit root, two radicand bits per stage
	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [RW-1:0] r_in, t, trial;
		logic [W+1:0]  q_in;
		logic [SW-1:0] l_in;
		logic          ge;

		if (k == 0) begin : g_head
			assign r_in = '0;
			assign q_in = '0;
			assign l_in = {4'b0000, s};
		end else begin : g_tail
			assign r_in = rem_s[k-1];
			assign q_in = root_s[k-1];
			assign l_in = lo_s[k-1];
		end

		assign t     = {r_in[RW-3:0], l_in[SW-1:SW-2]};
		assign trial = {q_in, 2'b01};
		assign ge    = t >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? t - trial : t;
				root_s[k] <= {q_in[W:0], ge};
				lo_s[k]   <= {l_in[SW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[NS-1];
	assign rem  = rem_s[NS-1];

endmodule

/* hw/rtl/complex_arith_unit.sv */
// Complex arithmetic unit: one operation on two complex fixed-point operands per word.
// Input channel: in_valid/in_stall with action, a_re, a_im, b_re, b_im. A word is taken
// at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with res_re, res_im, is_zero, status. The word is
// taken at a rising edge with out_valid high and out_stall low.
// Pipeline: four front stages (capture, products, sums, magnitude split), WORD_BITS+2
// divider/root stages producing one quotient or root bit each, and the output register.
// Throughput: one word per cycle while no output word is stalled, set by the fully
// pipelined divider and root units.
// Reset clears every valid bit; the pipeline comes up empty and out_valid low.
// A stalled output word freezes the whole pipeline and raises in_stall in the same
// cycle; nothing is dropped or repeated, and bubbles keep flowing while not stalled.
// Status: 0 ok, 1 divide by zero (results zero), 2 saturated.
module complex_arith_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  action,
	input  logic signed [WORD_BITS-1:0] a_re,
	input  logic signed [WORD_BITS-1:0] a_im,
	input  logic signed [WORD_BITS-1:0] b_re,
	input  logic signed [WORD_BITS-1:0] b_im,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] res_re,
	output logic signed [WORD_BITS-1:0] res_im,
	output logic                        is_zero,
	output logic [1:0]                  status
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int NS = W + 2;
	localparam int PW = 2*W + 1;

	localparam logic [PW-1:0] MAXP = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [PW-1:0] MAGN = {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
	localparam logic [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic [W-1:0]  SATP = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  SATN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		act_t         act;
		logic         denz;
		logic         neg_re;
		logic         neg_im;
		logic         sat;
		logic         zero;
		logic [W-1:0] re;
		logic [W-1:0] im;
	} side_t;

	logic            en;
	ctl_t            ctl;
	logic [2*W-1:0]  mag_re, mag_im, den;
	logic signed [W:0] qre, qim;
	logic [W+1:0]    q_re, q_im, root;
	logic            ovf_re, ovf_im;
	logic [W+3:0]    rem;
	logic [W:0]      r_re, r_im, f_re, f_im;
	logic [W+2:0]    rr;
	side_t           side_c, sd;
	side_t           side_s [NS];
	logic [NS-1:0]   vld_s;
	status_t         st;
	logic            out_vld_q, zero_q;
	logic [W-1:0]    re_q, im_q;
	status_t         st_q;

	function automatic logic [W:0] pack_f(input logic neg, input logic [PW-1:0] r);
		logic [W-1:0] rl;
		logic [W:0]   o;
		rl = r[W-1:0];
		if (!neg)
			o = (r > MAXP) ? {1'b1, SATP} : {1'b0, rl};
		else
			o = (r > MAGN) ? {1'b1, SATN} : {1'b0, ~rl + 1'b1};
		return o;
	endfunction

	function automatic logic [W:0] round_f(input logic neg, input logic [2*W-1:0] m);
		logic [PW-1:0] t;
		t = ({1'b0, m} + HALF) >> F;
		return pack_f(neg, t);
	endfunction

	function automatic logic [W:0] small_f(input logic signed [W:0] s);
		logic [W:0] m;
		m = $unsigned(s);
		if (s[W])
			m = ~m + 1'b1;
		return pack_f(s[W], PW'(m));
	endfunction

	function automatic logic [W:0] quot_f(input logic neg, input logic [W+1:0] q,
		input logic ovf);
		logic [W+2:0] t;
		t = {1'b0, q} + 1'b1;
		if (ovf)
			return pack_f(neg, {PW{1'b1}});
		return pack_f(neg, PW'(t[W+2:1]));
	endfunction

	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;

	cau_front #(.W(W), .F(F)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.action   (action),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.ctl      (ctl),
		.mag_re   (mag_re),
		.mag_im   (mag_im),
		.den      (den),
		.qre      (qre),
		.qim      (qim)
	);

	cau_div #(.W(W), .F(F)) u_div_re (
		.clk (clk),
		.en  (en),
		.mag (mag_re),
		.den (den),
		.quo (q_re),
		.ovf (ovf_re)
	);

	cau_div #(.W(W), .F(F)) u_div_im (
		.clk (clk),
		.en  (en),
		.mag (mag_im),
		.den (den),
		.quo (q_im),
		.ovf (ovf_im)
	);

	cau_sqrt #(.W(W)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.s    (den),
		.root (root),
		.rem  (rem)
	);

	// results that need no divider or root, delayed alongside those units
	always_comb begin
		r_re = '0;
		r_im = '0;
		case (ctl.act)
			ACT_ADD, ACT_SUB, ACT_CONJ: begin
				r_re = small_f(qre);
				r_im = small_f(qim);
			end
			ACT_MUL, ACT_SCALE: begin
				r_re = round_f(ctl.neg_re, mag_re);
				r_im = round_f(ctl.neg_im, mag_im);
			end
			ACT_SQMAG: r_re = round_f(1'b0, den);
			default: ;
		endcase
		side_c.act    = ctl.act;
		side_c.denz   = ctl.denz;
		side_c.neg_re = ctl.neg_re;
		side_c.neg_im = ctl.neg_im;
		side_c.sat    = r_re[W] | r_im[W];
		side_c.zero   = ctl.zero;
		side_c.re     = r_re[W-1:0];
		side_c.im     = r_im[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[NS-2:0], ctl.vld};
			out_vld_q <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_c;
			for (int k = 1; k < NS; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	always_comb begin
		sd   = side_s[NS-1];
		f_re = {1'b0, sd.re};
		f_im = {1'b0, sd.im};
		rr   = {1'b0, root} + (W+3)'(rem > {2'b00, root});
		st   = sd.sat ? ST_SAT : ST_OK;
		case (sd.act)
			ACT_DIV, ACT_RECIP: begin
				if (sd.denz) begin
					f_re = '0;
					f_im = '0;
					st   = ST_DIVZ;
				end else begin
					f_re = quot_f(sd.neg_re, q_re, ovf_re);
					f_im = quot_f(sd.neg_im, q_im, ovf_im);
					st   = (f_re[W] | f_im[W]) ? ST_SAT : ST_OK;
				end
			end
			ACT_MAG: begin
				f_re = pack_f(1'b0, PW'(rr));
				f_im = '0;
				st   = f_re[W] ? ST_SAT : ST_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q   <= f_re[W-1:0];
			im_q   <= f_im[W-1:0];
			zero_q <= sd.zero;
			st_q   <= st;
		end
	end

	assign out_valid = out_vld_q;
	assign res_re    = re_q;
	assign res_im    = im_q;
	assign is_zero   = zero_q;
	assign status    = st_q;

`ifndef ASSERT_OFF
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline valid bits moved while output word stalled");

	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DIVZ) |-> (res_re == '0) && (res_im == '0))
		else $error("divide by zero word with nonzero result");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_zero |-> (status == ST_OK) && (res_re == '0) && (res_im == '0))
		else $error("zero test word with nonzero result or status");
`endif

endmodule

/* bench/cau_checker.sv */
module cau_checker
	import cau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  action,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] res_re,
	input  logic [31:0] res_im,
	input  logic        is_zero,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        zero;
		logic [1:0]  st;
	} cplx_word_t;

	localparam logic [127:0] POS_MAX = 128'h7fff_ffff;
	localparam logic [127:0] NEG_MAX = 128'h8000_0000;
	localparam logic [127:0] QCAP    = 128'h2_0000_0000;

	cplx_word_t expected_q[$];

	function automatic logic [31:0] clamp_word(bit neg, logic [127:0] r, inout bit sat);
		logic [127:0] m;
		m = r;
		if (!neg) begin
			if (m > POS_MAX) begin
				sat = 1;
				m = POS_MAX;
			end
			return m[31:0];
		end
		if (m > NEG_MAX) begin
			sat = 1;
			m = NEG_MAX;
		end
		m = -m;
		return m[31:0];
	endfunction

	function automatic logic [31:0] exact_word(logic signed [127:0] v, inout bit sat);
		logic [127:0] m;
		m = (v < 0) ? -v : v;
		return clamp_word(v < 0, m, sat);
	endfunction

	function automatic logic [31:0] round_word(logic signed [127:0] v, inout bit sat);
		logic [127:0] m;
		m = (v < 0) ? -v : v;
		return clamp_word(v < 0, (m + 128'h8000) >> 16, sat);
	endfunction

	function automatic logic [31:0] quot_word(logic signed [127:0] v, logic [127:0] den,
			inout bit sat);
		logic [127:0] m;
		logic [127:0] q;
		m = (v < 0) ? -v : v;
		q = (m << 17) / den;
		if (q > QCAP)
			q = QCAP;
		else
			q = (q + 1) >> 1;
		return clamp_word(v < 0, q, sat);
	endfunction

	function automatic logic [63:0] root_rounded(logic [63:0] s);
		logic [63:0] op;
		logic [63:0] r;
		logic [63:0] b;
		op = s;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > op)
			b = b >> 2;
		while (b != 0) begin
			if (op >= r + b) begin
				op = op - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (op > r)
			r = r + 1;
		return r;
	endfunction

	function automatic cplx_word_t complex_result(logic [3:0] act, logic signed [31:0] ar,
			logic signed [31:0] ai, logic signed [31:0] br, logic signed [31:0] bi);
		cplx_word_t w;
		logic signed [127:0] xr, xi, yr, yi;
		logic [127:0] den;
		bit sat;
		bit divz;
		xr = ar;
		xi = ai;
		yr = br;
		yi = bi;
		sat = 0;
		divz = 0;
		w.re = 0;
		w.im = 0;
		w.zero = 0;
		case (act)
			ACT_ADD: begin
				w.re = exact_word(xr + yr, sat);
				w.im = exact_word(xi + yi, sat);
			end
			ACT_SUB: begin
				w.re = exact_word(xr - yr, sat);
				w.im = exact_word(xi - yi, sat);
			end
			ACT_MUL: begin
				w.re = round_word(xr * yr - xi * yi, sat);
				w.im = round_word(xr * yi + xi * yr, sat);
			end
			ACT_DIV: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					divz = 1;
				end else begin
					w.re = quot_word(xr * yr + xi * yi, den, sat);
					w.im = quot_word(xi * yr - xr * yi, den, sat);
				end
			end
			ACT_CONJ: begin
				w.re = exact_word(xr, sat);
				w.im = exact_word(-xi, sat);
			end
			ACT_SCALE: begin
				w.re = round_word(xr * yr, sat);
				w.im = round_word(xi * yr, sat);
			end
			ACT_MAG: begin
				den = xr * xr + xi * xi;
				w.re = clamp_word(0, {64'd0, root_rounded(den[63:0])}, sat);
			end
			ACT_SQMAG: begin
				w.re = round_word(xr * xr + xi * xi, sat);
			end
			ACT_RECIP: begin
				den = xr * xr + xi * xi;
				if (den == 0) begin
					divz = 1;
				end else begin
					w.re = quot_word(xr * 65536, den, sat);
					w.im = quot_word(-(xi * 65536), den, sat);
				end
			end
			ACT_ZERO: begin
				w.zero = (ar == 0 && ai == 0);
			end
			default: ;
		endcase
		w.st = divz ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cplx_word_t e;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(complex_result(action, a_re, a_im, b_re, b_im));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected word re=%h im=%h z=%b st=%0d", $time,
						res_re, res_im, is_zero, status);
					errors <= errors + 1;
				end else begin
					e = expected_q.pop_front();
					if (res_re !== e.re || res_im !== e.im || is_zero !== e.zero
							|| status !== e.st) begin
						$display("%0t: mismatch expected re=%h im=%h z=%b st=%0d", $time,
							e.re, e.im, e.zero, e.st);
						$display("%0t:          actual   re=%h im=%h z=%b st=%0d", $time,
							res_re, res_im, is_zero, status);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

/* bench/tb.sv */
module tb;
	import cau_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  action;
	logic [31:0] a_re, a_im, b_re, b_im;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] res_re, res_im;
	logic        is_zero;
	logic [1:0]  status;
	int          errors;
	int          pending;
	bit          busy_phase;

	complex_arith_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_re(res_re), .res_im(res_im), .is_zero(is_zero), .status(status)
	);

	cau_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_re(res_re), .res_im(res_im), .is_zero(is_zero), .status(status),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= busy_phase ? 1'b0 : ($urandom_range(99) < 35);
	end

	task automatic send_word(logic [3:0] act, logic [31:0] xr, logic [31:0] xi,
			logic [31:0] yr, logic [31:0] yi);
		in_valid <= 1'b1;
		action <= act;
		a_re <= xr;
		a_im <= xi;
		b_re <= yr;
		b_im <= yi;
		do
			@(posedge clk);
		while (in_stall);
		if (!busy_phase && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_part();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3, 4: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
			5: return 32'($signed($urandom_range(512)) - 256);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] pick_action();
		if ($urandom_range(99) < 4)
			return 4'($urandom_range(15, 10));
		return 4'($urandom_range(9));
	endfunction

	initial begin
		arst_n = 0;
		in_valid = 0;
		action = 0;
		a_re = 0;
		a_im = 0;
		b_re = 0;
		b_im = 0;
		busy_phase = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_word(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff);
		send_word(ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff);
		send_word(ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000, 32'h0000_8000);
		send_word(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_word(ACT_MUL, 32'h0000_0001, 32'd0, 32'h0000_8000, 32'd0);
		send_word(ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hfffc_0000);
		send_word(ACT_DIV, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
		send_word(ACT_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'd0);
		send_word(ACT_CONJ, 32'h1234_5678, 32'h8000_0000, 32'd0, 32'd0);
		send_word(ACT_CONJ, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0);
		send_word(ACT_SCALE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'd0);
		send_word(ACT_SCALE, 32'h0001_8000, 32'hfffe_8000, 32'h0000_8000, 32'd0);
		send_word(ACT_MAG, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0);
		send_word(ACT_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
		send_word(ACT_SQMAG, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0);
		send_word(ACT_SQMAG, 32'h0000_0100, 32'd0, 32'd0, 32'd0);
		send_word(ACT_RECIP, 32'd0, 32'd0, 32'd0, 32'd0);
		send_word(ACT_RECIP, 32'h0000_0001, 32'd0, 32'd0, 32'd0);
		send_word(ACT_RECIP, 32'h0002_0000, 32'hfffe_0000, 32'd0, 32'd0);
		send_word(ACT_ZERO, 32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
		send_word(ACT_ZERO, 32'd0, 32'd1, 32'd0, 32'd0);
		send_word(ACT_ZERO, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
		send_word(4'($urandom_range(15, 10)), 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff);

		for (int i = 0; i < 1200; i++) begin
			busy_phase = (i >= 500 && i < 750);
			send_word(pick_action(), pick_part(), pick_part(), pick_part(), pick_part());
		end
		busy_phase = 0;
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
